// File: src/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Included by the top level; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UCFP_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("ucfp assertion failed");
`define UCFP_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("ucfp assertion failed");
`else
`define UCFP_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons)
`define UCFP_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)
`endif
`endif

// File: src/ucfp_pkg.sv
// Constants and types for the UART command frame parser.
// No dependencies; imported by all parser modules.
package ucfp_pkg;

    localparam logic [7:0] TERMINATOR    = 8'h3C;
    localparam int         RFID_HDR_LEN  = 7;
    localparam int         GPS_HDR_LEN   = 6;
    localparam int         PAYLOAD_START = 7;

    // "rfid|R>", "rfid|W>", "gps|S>", "gps|E>"
    localparam logic [7:0] HDR_RFID_R [RFID_HDR_LEN] =
        '{8'h72, 8'h66, 8'h69, 8'h64, 8'h7C, 8'h52, 8'h3E};
    localparam logic [7:0] HDR_RFID_W [RFID_HDR_LEN] =
        '{8'h72, 8'h66, 8'h69, 8'h64, 8'h7C, 8'h57, 8'h3E};
    localparam logic [7:0] HDR_GPS_S [GPS_HDR_LEN] =
        '{8'h67, 8'h70, 8'h73, 8'h7C, 8'h53, 8'h3E};
    localparam logic [7:0] HDR_GPS_E [GPS_HDR_LEN] =
        '{8'h67, 8'h70, 8'h73, 8'h7C, 8'h45, 8'h3E};

    localparam logic [1:0] CMD_RFID_READ  = 2'd0;
    localparam logic [1:0] CMD_RFID_WRITE = 2'd1;
    localparam logic [1:0] CMD_GPS_START  = 2'd2;
    localparam logic [1:0] CMD_GPS_END    = 2'd3;

    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// File: src/ucfp_if.sv
// Word channels of the parser: received bytes in, command results out.
// No dependencies.
interface ucfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfp_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
    logic       overflowed;

    modport source (output valid, output command, output payload_length,
                    output payload_byte, output byte_valid, output last,
                    output overflowed, input ready);
    modport sink   (input valid, input command, input payload_length,
                    input payload_byte, input byte_valid, input last,
                    input overflowed, output ready);
endinterface

// File: src/uart_command_frame_parser.sv
// UART command frame parser: data words and the terminator are taken while idle; after the
// terminator, one result per cycle while the output side accepts (one for gps, one per
// payload byte for rfid or one if it has none, none on no match). The first result is
// registered once the state is S_EMIT; the chain shifts one place per payload result.
// Reset (rst_n, async, active low) empties the chain, the count and the overflow flag.
// Depends on ucfp_pkg, ucfp_if, ucfp_chain and assert_macros.svh.
`include "assert_macros.svh"

module uart_command_frame_parser
    import ucfp_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    ucfp_rx_if.sink     rx,
    ucfp_res_if.source  res
);

    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                ovf_reg, ovf_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [5:0]          plen_reg, plen_next;
    logic                single_reg, single_next;
    logic [FILL_W-1:0]   remaining_reg, remaining_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_cmd_reg, out_cmd_next;
    logic [5:0]          out_plen_reg, out_plen_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_bv_reg, out_bv_next;
    logic                out_last_reg, out_last_next;
    logic                out_ovf_reg, out_ovf_next;

    cell_ctrl_t          ctrl;
    logic [BUFFER_DEPTH-1:0] cell_valid;
    logic [7:0]          cell_data [BUFFER_DEPTH];

    logic                rx_fire;
    logic                out_free;
    logic                rfid_r, rfid_w, gps_s, gps_e;
    logic [FILL_W-1:0]   plen_rfid;
    logic [FILL_W-1:0]   plen_gps;

    ucfp_chain #(
        .DEPTH (BUFFER_DEPTH)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_byte    (rx.rx_byte),
        .cell_valid (cell_valid),
        .cell_data  (cell_data)
    );

    assign rx.ready  = (state_reg == S_IDLE);
    assign rx_fire   = rx.valid && rx.ready;
    assign out_free  = !out_valid_reg || res.ready;
    assign plen_rfid = fill_reg - FILL_W'(RFID_HDR_LEN);
    assign plen_gps  = fill_reg - FILL_W'(GPS_HDR_LEN);

    // header match over the front cells; empty cells never match
    always_comb
    begin
        rfid_r = 1'b1;
        rfid_w = 1'b1;
        gps_s  = 1'b1;
        gps_e  = 1'b1;
        for (int i = 0; i < RFID_HDR_LEN; i++)
        begin
            if (!cell_valid[i] || cell_data[i] != HDR_RFID_R[i])
            begin
                rfid_r = 1'b0;
            end
            if (!cell_valid[i] || cell_data[i] != HDR_RFID_W[i])
            begin
                rfid_w = 1'b0;
            end
        end
        for (int i = 0; i < GPS_HDR_LEN; i++)
        begin
            if (!cell_valid[i] || cell_data[i] != HDR_GPS_S[i])
            begin
                gps_s = 1'b0;
            end
            if (!cell_valid[i] || cell_data[i] != HDR_GPS_E[i])
            begin
                gps_e = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        cmd_next       = cmd_reg;
        plen_next      = plen_reg;
        single_next    = single_reg;
        remaining_next = remaining_reg;
        ctrl           = '0;

        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        out_cmd_next   = out_cmd_reg;
        out_plen_next  = out_plen_reg;
        out_byte_next  = out_byte_reg;
        out_bv_next    = out_bv_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (rx_fire)
                begin
                    if (rx.rx_byte != TERMINATOR)
                    begin
                        if (fill_reg < FILL_W'(BUFFER_DEPTH))
                        begin
                            ctrl.load = 1'b1;
                            fill_next = fill_reg + FILL_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        priority if (rfid_r || rfid_w)
                        begin
                            cmd_next       = rfid_r ? CMD_RFID_READ : CMD_RFID_WRITE;
                            plen_next      = plen_rfid[5:0];
                            remaining_next = plen_rfid;
                            single_next    = (plen_rfid == '0);
                            state_next     = S_EMIT;
                        end
                        else if (gps_s || gps_e)
                        begin
                            cmd_next    = gps_s ? CMD_GPS_START : CMD_GPS_END;
                            plen_next   = plen_gps[5:0];
                            single_next = 1'b1;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            ctrl.clear = 1'b1;
                            fill_next  = '0;
                            ovf_next   = 1'b0;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cmd_next   = cmd_reg;
                    out_plen_next  = plen_reg;
                    out_ovf_next   = ovf_reg;
                    if (single_reg)
                    begin
                        out_byte_next = 8'h00;
                        out_bv_next   = 1'b0;
                        out_last_next = 1'b1;
                    end
                    else
                    begin
                        // payload word sits in the cell just past the header
                        out_byte_next  = cell_data[PAYLOAD_START];
                        out_bv_next    = 1'b1;
                        out_last_next  = (remaining_reg == FILL_W'(1));
                        ctrl.shift     = 1'b1;
                        remaining_next = remaining_reg - FILL_W'(1);
                    end
                    if (single_reg || remaining_reg == FILL_W'(1))
                    begin
                        ctrl.clear = 1'b1;
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        plen_reg      <= plen_next;
        single_reg    <= single_next;
        remaining_reg <= remaining_next;
        out_cmd_reg   <= out_cmd_next;
        out_plen_reg  <= out_plen_next;
        out_byte_reg  <= out_byte_next;
        out_bv_reg    <= out_bv_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.command        = out_cmd_reg;
    assign res.payload_length = out_plen_reg;
    assign res.payload_byte   = out_byte_reg;
    assign res.byte_valid     = out_bv_reg;
    assign res.last           = out_last_reg;
    assign res.overflowed     = out_ovf_reg;

    `UCFP_ASSERT_IMPLY(a_fill_matches_cells, clk, rst_n, state_reg == S_IDLE,
        int'(fill_reg) == $countones(cell_valid))
    `UCFP_ASSERT_IMPLY(a_emit_has_work, clk, rst_n, state_reg == S_EMIT,
        single_reg || remaining_reg != '0)
    `UCFP_ASSERT_NEXT(a_nomatch_clears, clk, rst_n,
        rx_fire && rx.rx_byte == TERMINATOR && !rfid_r && !rfid_w && !gps_s && !gps_e,
        fill_reg == '0 && !ovf_reg && state_reg == S_IDLE)

endmodule

// File: src/ucfp_cell.sv
// One byte cell of the frame chain.
// Depends on ucfp_pkg.
module ucfp_cell
    import ucfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] in_byte,
    input  logic       prev_valid,
    input  logic       next_valid,
    input  logic [7:0] next_data,
    output logic       valid,
    output logic [7:0] data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
        else if (ctrl.load && !valid_reg && prev_valid)
        begin
            // first empty cell takes the word
            valid_next = 1'b1;
            data_next  = in_byte;
        end
        else
        begin
            valid_next = valid_reg;
            data_next  = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// File: src/ucfp_chain.sv
// Row of byte cells holding the frame; fills front to back, shifts toward cell 0.
// Depends on ucfp_pkg and ucfp_cell.
module ucfp_chain
    import ucfp_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [7:0]       in_byte,
    output logic [DEPTH-1:0] cell_valid,
    output logic [7:0]       cell_data [DEPTH]
);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic       prev_v;
            logic       next_v;
            logic [7:0] next_d;

            if (g == 0)
            begin : g_head
                assign prev_v = 1'b1;
            end
            else
            begin : g_body
                assign prev_v = cell_valid[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign next_v = 1'b0;
                assign next_d = 8'h00;
            end
            else
            begin : g_link
                assign next_v = cell_valid[g+1];
                assign next_d = cell_data[g+1];
            end

            ucfp_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .in_byte    (in_byte),
                .prev_valid (prev_v),
                .next_valid (next_v),
                .next_data  (next_d),
                .valid      (cell_valid[g]),
                .data       (cell_data[g])
            );
        end
    endgenerate

endmodule

// File: test/testbench.sv
// Self-checking bench for uart_command_frame_parser: byte frames in, command words out.
// Holds its own frame decoder and compares every result word in order.
// Depends on ucfp_pkg, ucfp_if and the parser RTL.
module testbench;
    import ucfp_pkg::*;

    localparam int STORE_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [55:0] RFID_READ_HDR  = "rfid|R>";
    localparam logic [55:0] RFID_WRITE_HDR = "rfid|W>";
    localparam logic [55:0] GPS_START_HDR  = "gps|S>";
    localparam logic [55:0] GPS_END_HDR    = "gps|E>";

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] payload_length;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
        logic       overflowed;
    } cmd_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ucfp_rx_if  rx_ch ();
    ucfp_res_if res_ch ();

    uart_command_frame_parser #(.BUFFER_DEPTH(STORE_DEPTH)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // decoder state
    logic [7:0]  frame_bytes [STORE_DEPTH];
    int          frame_fill;
    logic        frame_dropped;
    cmd_result_t cmd_results_due [$];

    logic [7:0]  rx_pending [$];
    int          bytes_sent;
    int          bytes_taken;
    logic        rx_taken;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          frames_seen;
    int          words_checked;
    int          overflow_frames;
    int          cycle_count;

    function automatic logic [7:0] stored_at(int pos);
        return (pos < frame_fill) ? frame_bytes[pos] : 8'h00;
    endfunction

    function automatic bit header_matches(logic [55:0] hdr, int len);
        for (int i = 0; i < len; i++)
        begin
            if (stored_at(i) != hdr[8 * (len - 1 - i) +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_frame();
        for (int i = 0; i < STORE_DEPTH; i++)
            frame_bytes[i] = 8'h00;
        frame_fill    = 0;
        frame_dropped = 1'b0;
    endfunction

    function automatic void decode_frame();
        cmd_result_t r;
        int          plen;
        r            = '0;
        r.overflowed = frame_dropped;
        r.last       = 1'b1;
        if (header_matches(RFID_READ_HDR, 7) || header_matches(RFID_WRITE_HDR, 7))
        begin
            r.command = header_matches(RFID_READ_HDR, 7) ? CMD_RFID_READ : CMD_RFID_WRITE;
            plen      = frame_fill - 7;
            if (plen == 0)
                cmd_results_due.push_back(r);
            else
            begin
                for (int i = 0; i < plen; i++)
                begin
                    r.payload_length = 6'(plen);
                    r.payload_byte   = stored_at(7 + i);
                    r.byte_valid     = 1'b1;
                    r.last           = (i == plen - 1);
                    cmd_results_due.push_back(r);
                end
            end
        end
        else if (header_matches(GPS_START_HDR, 6))
        begin
            r.command        = CMD_GPS_START;
            r.payload_length = 6'(frame_fill - 6);
            cmd_results_due.push_back(r);
        end
        else if (header_matches(GPS_END_HDR, 6))
        begin
            r.command        = CMD_GPS_END;
            r.payload_length = 6'(frame_fill - 6);
            cmd_results_due.push_back(r);
        end
        clear_frame();
    endfunction

    function automatic void take_rx_byte(logic [7:0] b);
        if (b != TERMINATOR)
        begin
            if (frame_fill < STORE_DEPTH)
            begin
                frame_bytes[frame_fill] = b;
                frame_fill++;
            end
            else
                frame_dropped = 1'b1;
        end
        else
        begin
            frames_seen++;
            if (frame_dropped)
                overflow_frames++;
            decode_frame();
        end
    endfunction

    function automatic void report(string field, int want, int got);
        $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endfunction

    // stimulus helpers
    function automatic void push_rx(logic [7:0] b);
        rx_pending.push_back(b);
        bytes_sent++;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_rx(s.getc(i));
    endfunction

    function automatic void push_payload(int n);
        logic [7:0] v;
        for (int i = 0; i < n; i++)
        begin
            v = 8'($urandom);
            if (v == TERMINATOR)
                v = ~v;
            push_rx(v);
        end
    endfunction

    function automatic string header_text(int k);
        case (k)
            0:       return "rfid|R>";
            1:       return "rfid|W>";
            2:       return "gps|S>";
            default: return "gps|E>";
        endcase
    endfunction

    // returns a rough count of the words the frame should produce
    function automatic int add_random_frame();
        int    kind;
        int    n;
        int    k;
        int    pos;
        string h;
        kind = $urandom_range(0, 99);
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 57) : $urandom_range(0, 8);
        k    = $urandom_range(0, 3);
        h    = header_text(k);
        if (kind < 60)
        begin
            push_text(h);
            push_payload(n);
            push_rx(TERMINATOR);
            return (k < 2 && n > 0) ? n : 1;
        end
        else if (kind < 75)
        begin
            pos = $urandom_range(0, h.len() - 1);
            if ($urandom_range(0, 1))
                h.putc(pos, h.getc(pos) ^ (8'h01 << $urandom_range(0, 7)));
            else
                h = h.substr(0, pos - 1);
            push_text(h);
            push_payload($urandom_range(0, 4));
            push_rx(TERMINATOR);
            return 0;
        end
        else if (kind < 92)
        begin
            repeat ($urandom_range(0, 6))
                push_rx(8'($urandom));
            push_rx(TERMINATOR);
            return 0;
        end
        else
        begin
            push_text(h);
            push_payload($urandom_range(55, 66));
            push_rx(TERMINATOR);
            return (k < 2) ? 57 : 1;
        end
    endfunction

    // driver: new inputs at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!rx_ch.valid || rx_taken)
            begin
                if (rx_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= rx_pending.pop_front();
                end
                else
                begin
                    rx_ch.valid   <= 1'b0;
                    rx_ch.rx_byte <= 8'($urandom);
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: handshakes sampled at the rising edge
    always @(posedge clk)
    begin
        cmd_result_t want;
        cmd_result_t got;
        rx_taken = rst_n && rx_ch.valid && rx_ch.ready;
        if (rx_taken)
        begin
            bytes_taken++;
            take_rx_byte(rx_ch.rx_byte);
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.command        = res_ch.command;
            got.payload_length = res_ch.payload_length;
            got.payload_byte   = res_ch.payload_byte;
            got.byte_valid     = res_ch.byte_valid;
            got.last           = res_ch.last;
            got.overflowed     = res_ch.overflowed;
            if (cmd_results_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                error_count++;
            end
            else
            begin
                want = cmd_results_due.pop_front();
                words_checked++;
                if (got.command !== want.command)
                    report("command", want.command, got.command);
                if (got.payload_length !== want.payload_length)
                    report("payload_length", want.payload_length, got.payload_length);
                if (got.payload_byte !== want.payload_byte)
                    report("payload_byte", want.payload_byte, got.payload_byte);
                if (got.byte_valid !== want.byte_valid)
                    report("byte_valid", want.byte_valid, got.byte_valid);
                if (got.last !== want.last)
                    report("last", want.last, got.last);
                if (got.overflowed !== want.overflowed)
                    report("overflowed", want.overflowed, got.overflowed);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d words still due", cycle_count,
                 cmd_results_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int phase_bytes;
        int phase_words;
        rst_n           = 1'b0;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = 8'h00;
        res_ch.ready    = 1'b0;
        rx_taken        = 1'b0;
        bytes_sent      = 0;
        bytes_taken     = 0;
        error_count     = 0;
        frames_seen     = 0;
        words_checked   = 0;
        overflow_frames = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        clear_frame();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 32 : 0;
            phase_bytes   = bytes_sent;
            phase_words   = 0;
            if (phase == 0)
            begin
                push_rx(TERMINATOR);
                push_text("rfid|R><");
                push_text("rfid|W>");
                push_rx(8'h00);
                push_rx(8'hFF);
                push_rx(TERMINATOR);
                push_text("gps|S><");
                push_text("gps|E>");
                push_rx(8'hFF);
                push_rx(TERMINATOR);
                phase_words = 5;
            end
            else if (phase == 1)
            begin
                // store filled, then one byte dropped
                push_text("rfid|R>");
                push_payload(58);
                push_rx(TERMINATOR);
                phase_words = 57;
            end
            while (bytes_sent - phase_bytes < 10 || phase_words < 2)
                phase_words += add_random_frame();
            while (bytes_taken != bytes_sent || cmd_results_due.size() != 0)
                @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d bytes in %0d frames, %0d over capacity", bytes_taken,
                 frames_seen, overflow_frames);
        $display("Checked %0d command words, %0d errors", words_checked, error_count);
        if (error_count == 0 && cmd_results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: uart_command_frame_parser.f
+incdir+src
src/ucfp_pkg.sv
src/ucfp_if.sv
src/ucfp_cell.sv
src/ucfp_chain.sv
src/uart_command_frame_parser.sv
test/testbench.sv
